### sv/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg: shared constants and helpers of the buddy block allocator
// Tree geometry, field widths, result codes and heap-order node numbering.
// ----------------------------------------------------------------------------
`default_nettype none

package bba_pkg;

   localparam int LEVELS    = 8;
   localparam int LVL_W     = $clog2(LEVELS + 1);
   localparam int POS_W     = (LEVELS > 1) ? LEVELS - 1 : 1;
   localparam int NODE_W    = LEVELS;
   localparam int NODE_LAST = (1 << LEVELS) - 2;
   localparam int MIN_W     = 16;
   localparam int SIZE_W    = 24;
   localparam int OFF_IN_W  = 24;
   localparam int OFF_OUT_W = 23;
   localparam int STAT_W    = 2;
   localparam int ACC_W     = MIN_W + POS_W;
   localparam int CMP_W     = 32;
   localparam int PROD_W    = MIN_W + POS_W + LEVELS;

   localparam logic [MIN_W-1:0] MIN_RESET = MIN_W'(16);

   localparam logic [STAT_W-1:0] ST_DONE     = 2'd0;
   localparam logic [STAT_W-1:0] ST_NOFIT    = 2'd1;
   localparam logic [STAT_W-1:0] ST_ZERO     = 2'd2;
   localparam logic [STAT_W-1:0] ST_FREE_IGN = 2'd3;

   localparam logic MODE_ALLOC = 1'b0;
   localparam logic MODE_FREE  = 1'b1;

   typedef logic [NODE_W-1:0] node_type;

   // heap order: node (2^level - 1 + pos)
   function automatic node_type node_id(input logic [LVL_W-1:0] lvl,
                                        input logic [POS_W-1:0] pos);
      node_id = (node_type'(1) << lvl) - node_type'(1) + node_type'(pos);
   endfunction

endpackage

`default_nettype wire

### sv/bba_bitmem.sv
// ----------------------------------------------------------------------------
// bba_bitmem: one-bit-wide tree memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_bitmem (
   input  wire logic                   clock,
   input  wire logic                   wr_en,
   input  wire logic [bba_pkg::NODE_W-1:0] wr_addr,
   input  wire logic                   wr_data,
   input  wire logic [bba_pkg::NODE_W-1:0] rd_addr,
   output logic                        rd_data
);
   import bba_pkg::*;

   logic mem [0:(1 << NODE_W) - 1];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

### sv/buddy_block_allocator_core.sv
// ----------------------------------------------------------------------------
// buddy_block_allocator_core: binary buddy allocator over an occupancy tree
// Allocates power-of-two runs of minimum blocks and frees them by offset.
//
//   channel  | handshake              | payload
//   request  | start / busy           | req_mode, req_request_size,
//            |                        | req_block_offset
//   response | rsp_valid (one cycle)  | rsp_granted_offset, rsp_status
//   config   | csr_wr_en              | csr_wr_data (min block bytes)
//
// An item is taken when start is high and busy low; busy stays high until
// its result strobe. A zero-size allocate is answered from idle without
// raising busy. Allocate: up to 8 size steps, then a scan of the nodes
// of the fitting level, a subtree fill and an ancestor walk. Free: up to
// 128 offset match steps, level probes, then subtree and ancestor walk.
// The tree memories, each with one write and one read port, set the pace.
// After reset a clearing pass over every tree node runs with busy high.
// The receiver cannot stall: each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module buddy_block_allocator_core (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   output logic                                busy,
   input  wire logic                           req_mode,
   input  wire logic [bba_pkg::SIZE_W-1:0]     req_request_size,
   input  wire logic [bba_pkg::OFF_IN_W-1:0]   req_block_offset,
   output logic                                rsp_valid,
   output logic [bba_pkg::OFF_OUT_W-1:0]       rsp_granted_offset,
   output logic [bba_pkg::STAT_W-1:0]          rsp_status,
   input  wire logic                           csr_wr_en,
   input  wire logic [bba_pkg::MIN_W-1:0]      csr_wr_data
);
   import bba_pkg::*;

   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_SIZE  = 4'd2;
   localparam logic [3:0] S_SCAN  = 4'd3;
   localparam logic [3:0] S_SCANC = 4'd4;
   localparam logic [3:0] S_SUB   = 4'd5;
   localparam logic [3:0] S_ANC   = 4'd6;
   localparam logic [3:0] S_MARK  = 4'd7;
   localparam logic [3:0] S_QSCAN = 4'd8;
   localparam logic [3:0] S_FLVL  = 4'd9;
   localparam logic [3:0] S_FCHK  = 4'd10;
   localparam logic [3:0] S_CA    = 4'd11;
   localparam logic [3:0] S_CAR   = 4'd12;
   localparam logic [3:0] S_CAC   = 4'd13;

   localparam logic [LVL_W-1:0] LVL_LAST = LVL_W'(LEVELS - 1);

   logic [3:0]           state_ff, state_in;
   logic [MIN_W-1:0]     min_ff;
   logic                 mode_ff, mode_in;
   logic [SIZE_W-1:0]    size_ff, size_in;
   logic [OFF_IN_W-1:0]  off_ff, off_in;
   logic [LVL_W-1:0]     e_ff, e_in;
   logic [LVL_W-1:0]     lvl_ff, lvl_in;
   logic [POS_W-1:0]     pos_ff, pos_in;
   logic [LVL_W-1:0]     sub_m_ff, sub_m_in;
   logic [POS_W-1:0]     sub_k_ff, sub_k_in;
   logic                 fill_ff, fill_in;
   logic [LVL_W-1:0]     walk_lvl_ff, walk_lvl_in;
   logic [POS_W-1:0]     walk_pos_ff, walk_pos_in;
   logic [ACC_W-1:0]     acc_ff, acc_in;
   logic [POS_W-1:0]     q_ff, q_in;
   logic                 left_ff, left_in;
   node_type             clr_ff, clr_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [OFF_OUT_W-1:0] rsp_off_ff, rsp_off_in;
   logic [STAT_W-1:0]    rsp_status_ff, rsp_status_in;

   logic                 busy_we, busy_wd, busy_rd;
   logic                 mark_we, mark_wd, mark_rd;
   node_type             busy_wa, mark_wa, rd_addr;

   logic [LVL_W-1:0]     sub_d, free_sh;
   logic [POS_W-1:0]     span_last, scan_last, qpos;
   node_type             sub_addr, parent_addr, left_addr;
   logic [PROD_W-1:0]    prod;

   always_comb begin
      sub_d       = sub_m_ff - lvl_ff;
      span_last   = (POS_W'(1) << sub_d) - POS_W'(1);
      sub_addr    = node_id(sub_m_ff, '0) + (node_type'(pos_ff) << sub_d)
                    + node_type'(sub_k_ff);
      scan_last   = (POS_W'(1) << lvl_ff) - POS_W'(1);
      free_sh     = LVL_LAST - lvl_ff;
      qpos        = q_ff >> free_sh;
      parent_addr = node_id(walk_lvl_ff - LVL_W'(1), walk_pos_ff >> 1);
      left_addr   = node_id(walk_lvl_ff, walk_pos_ff & ~POS_W'(1));
      prod        = PROD_W'(PROD_W'(pos_ff) * PROD_W'(min_ff)) << e_ff;
   end

   always_comb begin
      case (state_ff)
         S_SCAN:  rd_addr = node_id(lvl_ff, pos_ff);
         S_FLVL:  rd_addr = node_id(lvl_ff, qpos);
         S_CA:    rd_addr = left_addr;
         S_CAR:   rd_addr = left_addr + node_type'(1);
         default: rd_addr = '0;
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      size_in       = size_ff;
      off_in        = off_ff;
      e_in          = e_ff;
      lvl_in        = lvl_ff;
      pos_in        = pos_ff;
      sub_m_in      = sub_m_ff;
      sub_k_in      = sub_k_ff;
      fill_in       = fill_ff;
      walk_lvl_in   = walk_lvl_ff;
      walk_pos_in   = walk_pos_ff;
      acc_in        = acc_ff;
      q_in          = q_ff;
      left_in       = left_ff;
      clr_in        = clr_ff;
      rsp_valid_in  = 1'b0;
      rsp_off_in    = '0;
      rsp_status_in = ST_DONE;
      busy_we       = 1'b0;
      busy_wa       = '0;
      busy_wd       = 1'b0;
      mark_we       = 1'b0;
      mark_wa       = '0;
      mark_wd       = 1'b0;

      case (state_ff)
         S_CLEAR: begin
            busy_we = 1'b1;
            busy_wa = clr_ff;
            mark_we = 1'b1;
            mark_wa = clr_ff;
            if (clr_ff == node_type'(NODE_LAST)) begin
               state_in = S_IDLE;
            end else begin
               clr_in = clr_ff + node_type'(1);
            end
         end
         S_IDLE: begin
            if (start) begin
               mode_in = req_mode;
               size_in = req_request_size;
               off_in  = req_block_offset;
               e_in    = '0;
               acc_in  = '0;
               q_in    = '0;
               if (req_mode == MODE_FREE) begin
                  state_in = S_QSCAN;
               end else if (req_request_size == '0) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_ZERO;
               end else begin
                  state_in = S_SIZE;
               end
            end
         end
         // smallest e with size <= min_block << e
         S_SIZE: begin
            if (CMP_W'(size_ff) <= (CMP_W'(min_ff) << e_ff)) begin
               lvl_in   = LVL_LAST - e_ff;
               pos_in   = '0;
               state_in = S_SCAN;
            end else if (e_ff == LVL_LAST) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_NOFIT;
               state_in      = S_IDLE;
            end else begin
               e_in = e_ff + LVL_W'(1);
            end
         end
         S_SCAN: begin
            state_in = S_SCANC;
         end
         S_SCANC: begin
            if (!busy_rd) begin
               sub_m_in    = lvl_ff;
               sub_k_in    = '0;
               fill_in     = 1'b1;
               walk_lvl_in = lvl_ff;
               walk_pos_in = pos_ff;
               state_in    = S_SUB;
            end else if (pos_ff == scan_last) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_NOFIT;
               state_in      = S_IDLE;
            end else begin
               pos_in   = pos_ff + POS_W'(1);
               state_in = S_SCAN;
            end
         end
         S_SUB: begin
            busy_we = 1'b1;
            busy_wa = sub_addr;
            busy_wd = fill_ff;
            if (sub_k_ff == span_last) begin
               sub_k_in = '0;
               if (sub_m_ff == LVL_LAST) begin
                  state_in = (mode_ff == MODE_FREE) ? S_CA : S_ANC;
               end else begin
                  sub_m_in = sub_m_ff + LVL_W'(1);
               end
            end else begin
               sub_k_in = sub_k_ff + POS_W'(1);
            end
         end
         S_ANC: begin
            if (walk_lvl_ff == '0) begin
               state_in = S_MARK;
            end else begin
               busy_we     = 1'b1;
               busy_wa     = parent_addr;
               busy_wd     = 1'b1;
               walk_lvl_in = walk_lvl_ff - LVL_W'(1);
               walk_pos_in = walk_pos_ff >> 1;
            end
         end
         S_MARK: begin
            mark_we       = 1'b1;
            mark_wa       = node_id(lvl_ff, pos_ff);
            mark_wd       = 1'b1;
            rsp_valid_in  = 1'b1;
            rsp_off_in    = prod[OFF_OUT_W-1:0];
            rsp_status_in = ST_DONE;
            state_in      = S_IDLE;
         end
         // find q with q * min_block == offset
         S_QSCAN: begin
            if (CMP_W'(acc_ff) == CMP_W'(off_ff)) begin
               lvl_in   = '0;
               state_in = S_FLVL;
            end else if (q_ff == '1) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_FREE_IGN;
               state_in      = S_IDLE;
            end else begin
               acc_in = acc_ff + ACC_W'(min_ff);
               q_in   = q_ff + POS_W'(1);
            end
         end
         S_FLVL: begin
            if ((qpos << free_sh) == q_ff) begin
               state_in = S_FCHK;
            end else begin
               lvl_in = lvl_ff + LVL_W'(1);
            end
         end
         S_FCHK: begin
            if (mark_rd) begin
               mark_we     = 1'b1;
               mark_wa     = node_id(lvl_ff, qpos);
               mark_wd     = 1'b0;
               pos_in      = qpos;
               sub_m_in    = lvl_ff;
               sub_k_in    = '0;
               fill_in     = 1'b0;
               walk_lvl_in = lvl_ff;
               walk_pos_in = qpos;
               state_in    = S_SUB;
            end else if (lvl_ff == LVL_LAST) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_FREE_IGN;
               state_in      = S_IDLE;
            end else begin
               lvl_in   = lvl_ff + LVL_W'(1);
               state_in = S_FLVL;
            end
         end
         S_CA: begin
            if (walk_lvl_ff == '0) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_DONE;
               state_in      = S_IDLE;
            end else begin
               state_in = S_CAR;
            end
         end
         S_CAR: begin
            left_in  = busy_rd;
            state_in = S_CAC;
         end
         // parent cleared only while both children are free
         S_CAC: begin
            if (left_ff || busy_rd) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_DONE;
               state_in      = S_IDLE;
            end else begin
               busy_we     = 1'b1;
               busy_wa     = parent_addr;
               busy_wd     = 1'b0;
               walk_lvl_in = walk_lvl_ff - LVL_W'(1);
               walk_pos_in = walk_pos_ff >> 1;
               state_in    = S_CA;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         min_ff       <= MIN_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            min_ff <= (csr_wr_data == '0) ? MIN_W'(1) : csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      size_ff       <= size_in;
      off_ff        <= off_in;
      e_ff          <= e_in;
      lvl_ff        <= lvl_in;
      pos_ff        <= pos_in;
      sub_m_ff      <= sub_m_in;
      sub_k_ff      <= sub_k_in;
      fill_ff       <= fill_in;
      walk_lvl_ff   <= walk_lvl_in;
      walk_pos_ff   <= walk_pos_in;
      acc_ff        <= acc_in;
      q_ff          <= q_in;
      left_ff       <= left_in;
      rsp_off_ff    <= rsp_off_in;
      rsp_status_ff <= rsp_status_in;
   end

   bba_bitmem u_busy_mem (
      .clock   (clock),
      .wr_en   (busy_we),
      .wr_addr (busy_wa),
      .wr_data (busy_wd),
      .rd_addr (rd_addr),
      .rd_data (busy_rd)
   );

   bba_bitmem u_mark_mem (
      .clock   (clock),
      .wr_en   (mark_we),
      .wr_addr (mark_wa),
      .wr_data (mark_wd),
      .rd_addr (rd_addr),
      .rd_data (mark_rd)
   );

   assign busy               = (state_ff != S_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_granted_offset = rsp_off_ff;
   assign rsp_status         = rsp_status_ff;

endmodule

`default_nettype wire

### sv/bba_checker.sv
// ----------------------------------------------------------------------------
// bba_checker: port-level checks of the buddy block allocator
// Watches the top-level ports over time; bound to the top level below.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           start,
   input wire logic                           busy,
   input wire logic                           req_mode,
   input wire logic [bba_pkg::SIZE_W-1:0]     req_request_size,
   input wire logic                           rsp_valid,
   input wire logic [bba_pkg::OFF_OUT_W-1:0]  rsp_granted_offset,
   input wire logic [bba_pkg::STAT_W-1:0]     rsp_status
);
   import bba_pkg::*;

   // clearing pass follows reset
   a_reset_clears: assert property (@(posedge clock) reset |=> busy)
      else $error("busy not raised after reset");

   a_result_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while busy");

   a_fail_offset: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_DONE) |-> (rsp_granted_offset == '0))
      else $error("nonzero offset on a failed item");

   a_zero_size: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_ZERO) |->
         $past(start && !busy && req_mode == MODE_ALLOC && req_request_size == '0))
      else $error("zero-size status without a zero-size allocate");

endmodule

bind buddy_block_allocator_core bba_checker u_bba_checker (.*);

`default_nettype wire
